// ===== rtl/olist_pkg.sv =====
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants of the ordered value list: command and status
// codes, sequencer states, payload types and the default list depth.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned VALUE_W       = 32;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic        [VALUE_W-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_SEARCH  = 2'd2,
    CMD_DISPLAY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_DONE     = 3'd0,
    STAT_FOUND    = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_FULL     = 3'd4,
    STAT_ENTRY    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DISP,
    S_EMIT
  } state_t;

endpackage

// ===== rtl/olist_req_if.sv =====
// ----------------------------------------------------------------------------
// olist_req_if
// Request channel of the ordered value list: command and operand value.
// ----------------------------------------------------------------------------
interface olist_req_if import olist_pkg::*; ();

  logic   valid;
  logic   ready;
  cmd_t   command;
  value_t value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);

endinterface

// ===== rtl/olist_rsp_if.sv =====
// ----------------------------------------------------------------------------
// olist_rsp_if
// Response channel of the ordered value list: status, listed entry and the
// last-result mark.
// ----------------------------------------------------------------------------
interface olist_rsp_if import olist_pkg::*; ();

  logic    valid;
  logic    ready;
  status_t status;
  value_t  entry;
  logic    last;

  modport source (output valid, output status, output entry, output last, input ready);
  modport sink   (input valid, input status, input entry, input last, output ready);

endinterface

// ===== rtl/olist_ram.sv =====
// ----------------------------------------------------------------------------
// olist_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module olist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/ordered_list_insert_delete_search_top.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_search_top
// Ordered list of up to DEPTH signed 32-bit values kept in insertion order,
// with add-at-tail, delete-first-match, search and display commands.
// ----------------------------------------------------------------------------
//
//   channel    dir  payload                          one transfer carries
//   ---------  ---  -------------------------------  ---------------------------
//   request    in   command[1:0], value[31:0]        one command
//   response   out  status[2:0], entry[31:0], last   one result (last marks end)
//
// Add and any command on an empty list go from accept to result directly.
// Search compares entries one by one, up to the list length; delete then
// moves each entry behind the match one place toward the head. Display
// emits one entry per cycle while the response side takes them. The single
// read port of the entry RAM and its one compare set this pace. Reset
// clears the state, the entry count and the output valid; the RAM is not
// swept. A stalled response holds its result; request.ready stays low until
// the command's last result has entered the output register.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_search_top import olist_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  olist_req_if.sink   request,
  olist_rsp_if.source response
);

  // Index addresses the RAM; count also holds DEPTH itself.
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_t          state, state_next;
  logic [IW-1:0]   idx, idx_next;
  logic [CW-1:0]   count, count_next;
  cmd_t            cmd, cmd_next;
  value_t          val, val_next;
  status_t         pend, pend_next;

  logic            out_valid;
  status_t         out_status;
  value_t          out_entry;
  logic            out_last;

  logic            out_load;
  status_t         load_status;
  value_t          load_entry;
  logic            load_last;

  logic            ram_we;
  logic [IW-1:0]   wr_addr;
  word_t           wr_data;
  logic [IW-1:0]   rd_addr;
  word_t           rd_data;

  logic            req_xfer;
  logic            out_free;
  logic            full;
  logic            hit;
  logic [CW-1:0]   idx_ext;
  logic [CW-1:0]   idx_p1;
  logic [CW-1:0]   idx_p2;

  olist_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign request.ready = (state == S_IDLE);
  assign req_xfer      = request.valid && request.ready;
  assign out_free      = !out_valid || response.ready;
  assign full          = (count == CW'(DEPTH));

  // Shared compare: RAM word against the held operand.
  assign hit     = (rd_data == word_t'(val));
  assign idx_ext = CW'(idx);
  assign idx_p1  = idx_ext + CW'(1);
  assign idx_p2  = idx_ext + CW'(2);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_xfer) begin
          if (request.command == CMD_ADD || count == '0) begin
            state_next = S_EMIT;
          end else if (request.command == CMD_DISPLAY) begin
            state_next = S_DISP;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (cmd == CMD_DELETE && idx_p1 < count) begin
            state_next = S_SHIFT;
          end else begin
            state_next = S_EMIT;
          end
        end else if (idx_p1 == count) begin
          state_next = S_EMIT;
        end
      end
      S_SHIFT: begin
        if (!(idx_p2 < count)) begin
          state_next = S_EMIT;
        end
      end
      S_DISP: begin
        if (out_free && idx_p1 == count) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath control: RAM ports, index and count updates, result loads.
  always_comb begin
    idx_next    = idx;
    count_next  = count;
    cmd_next    = cmd;
    val_next    = val;
    pend_next   = pend;
    ram_we      = 1'b0;
    wr_addr     = idx;
    wr_data     = rd_data;
    rd_addr     = '0;
    out_load    = 1'b0;
    load_status = pend;
    load_entry  = '0;
    load_last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        // Read the head now so the scan or display sees it next cycle.
        if (req_xfer) begin
          cmd_next = request.command;
          val_next = request.value;
          idx_next = '0;
          if (request.command == CMD_ADD) begin
            if (full) begin
              pend_next = STAT_FULL;
            end else begin
              ram_we     = 1'b1;
              wr_addr    = count[IW-1:0];
              wr_data    = word_t'(request.value);
              count_next = count + CW'(1);
              pend_next  = STAT_DONE;
            end
          end else if (count == '0) begin
            pend_next = STAT_EMPTY;
          end
        end
      end
      S_SCAN: begin
        rd_addr = idx_p1[IW-1:0];
        if (hit) begin
          if (cmd == CMD_SEARCH) begin
            pend_next = STAT_FOUND;
          end else begin
            pend_next = STAT_DONE;
            if (!(idx_p1 < count)) begin
              count_next = count - CW'(1);
            end
          end
        end else if (idx_p1 == count) begin
          pend_next = STAT_NOTFOUND;
        end else begin
          idx_next = idx_p1[IW-1:0];
        end
      end
      S_SHIFT: begin
        // Move the next entry one place toward the head.
        ram_we  = 1'b1;
        wr_addr = idx;
        wr_data = rd_data;
        rd_addr = idx_p2[IW-1:0];
        if (idx_p2 < count) begin
          idx_next = idx_p1[IW-1:0];
        end else begin
          count_next = count - CW'(1);
        end
      end
      S_DISP: begin
        if (out_free) begin
          out_load    = 1'b1;
          load_status = STAT_ENTRY;
          load_entry  = value_t'(rd_data);
          load_last   = (idx_p1 == count);
          rd_addr     = idx_p1[IW-1:0];
          idx_next    = idx_p1[IW-1:0];
        end else begin
          // Hold: re-read the same entry while the output stalls.
          rd_addr = idx;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    cmd  <= cmd_next;
    val  <= val_next;
    pend <= pend_next;
  end

  // Output register: parts the sequencer from the response side.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= load_status;
      out_entry  <= load_entry;
      out_last   <= load_last;
    end
  end

  assign response.valid  = out_valid;
  assign response.status = out_status;
  assign response.entry  = out_entry;
  assign response.last   = out_last;

  // The list never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // An add transfer into a list with room grows it by exactly one.
  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && request.command == CMD_ADD && !full)
      |=> (count == $past(count) + CW'(1)))
    else $error("add did not grow the list");

  // The scan only visits slots that hold entries.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_SHIFT) |-> (idx_ext < count))
    else $error("scan index beyond list");

endmodule

// ===== bench/tb_ordered_list_insert_delete_search_top.sv =====
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_delete_search_top
// Self-checking bench for the ordered value list. A clocked driver feeds
// commands from a queue of pending commands, and a clocked monitor mirrors
// every accepted command on a model list. The monitor then checks each
// response transfer, field by field, against the oldest predicted result.
// Directed commands cover the empty list, the full list, value extremes,
// misses and duplicates. Random grow and shrink bursts follow. They run
// under three idling profiles on the request and response sides.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_delete_search_top import olist_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_DEPTH  = DEPTH_DEFAULT;
  // Slowest correct run: ~260 commands, each up to 16 results, each result
  // possibly held by a long response stall. Take it several times over.
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RANDOM_CMDS = 78;      // per idling profile
  localparam int          BURST_LEN   = 24;      // grow/shrink burst length
  localparam int          DRAIN_WAIT  = 40;      // quiet cycles at the end

  typedef struct packed {
    cmd_t   command;
    value_t value;
  } list_cmd_t;

  typedef struct packed {
    status_t status;
    value_t  entry;
    logic    last;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  olist_req_if req_ch ();
  olist_rsp_if rsp_ch ();

  ordered_list_insert_delete_search_top #(
    .DEPTH (LIST_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch)
  );

  // Commands waiting for the driver, the model list as the monitor sees it,
  // and the results the block still owes.
  list_cmd_t    pending_cmds[$];
  value_t       model_list[$];
  list_result_t owed_results[$];

  // Values that recur so that deletes and searches hit often; the extremes
  // of the signed range sit among them.
  value_t value_pool [8] = '{
    value_t'(32'h8000_0000), value_t'(32'h7fff_ffff), value_t'(32'h0000_0000),
    value_t'(32'hffff_ffff), value_t'(32'h0000_0001), value_t'(32'h5555_5555),
    value_t'(32'haaaa_aaaa), value_t'(32'h0000_0007)
  };

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   error_count   = 0;
  int   cycle_count   = 0;
  logic req_taken     = 1'b0;

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted command to the model list and queue what it owes.
  function automatic void apply_list_command(cmd_t command, value_t value);
    list_result_t res;
    int           hit;
    res.status = STAT_DONE;
    res.entry  = '0;
    res.last   = 1'b1;
    hit        = -1;
    foreach (model_list[i]) begin
      if (hit < 0 && model_list[i] == value) begin
        hit = i;
      end
    end
    if (command == CMD_ADD) begin
      if (model_list.size() >= LIST_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        model_list.push_back(value);
      end
      owed_results.push_back(res);
    end else if (model_list.size() == 0) begin
      res.status = STAT_EMPTY;
      owed_results.push_back(res);
    end else if (command == CMD_DELETE) begin
      if (hit < 0) begin
        res.status = STAT_NOTFOUND;
      end else begin
        model_list.delete(hit);
      end
      owed_results.push_back(res);
    end else if (command == CMD_SEARCH) begin
      res.status = (hit < 0) ? STAT_NOTFOUND : STAT_FOUND;
      owed_results.push_back(res);
    end else begin
      foreach (model_list[i]) begin
        res.status = STAT_ENTRY;
        res.entry  = model_list[i];
        res.last   = (i == model_list.size() - 1);
        owed_results.push_back(res);
      end
    end
  endfunction

  // Pick an operand: mostly a recurring value, sometimes any 32-bit word.
  function automatic value_t pick_value();
    if ($urandom_range(99) < 75) begin
      return value_pool[$urandom_range(7)];
    end
    return value_t'($urandom);
  endfunction

  function automatic void queue_cmd(cmd_t command, value_t value);
    list_cmd_t item;
    item.command = command;
    item.value   = value;
    pending_cmds.push_back(item);
  endfunction

  // Driver: change inputs on the falling edge. Advance to the next command
  // only once the current one has transferred, and idle at random in between.
  always @(negedge clk) begin
    list_cmd_t item;
    if (rst) begin
      req_ch.valid <= 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (!req_ch.valid || req_taken) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item = pending_cmds.pop_front();
          req_ch.valid   <= 1'b1;
          req_ch.command <= item.command;
          req_ch.value   <= item.value;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: sample both channels on the rising edge. Predict on every
  // request transfer; check every response transfer against the oldest
  // owed result.
  always @(posedge clk) begin
    list_result_t want;
    cycle_count++;
    req_taken = 1'b0;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        req_taken = 1'b1;
        apply_list_command(req_ch.command, req_ch.value);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected response: status %0d entry %0d last %0b",
                 rsp_ch.status, rsp_ch.entry, rsp_ch.last);
          error_count++;
        end else begin
          want = owed_results.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            error_count++;
          end
          if (rsp_ch.entry !== want.entry) begin
            $error("entry: expected %0d, got %0d", want.entry, rsp_ch.entry);
            error_count++;
          end
          if (rsp_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
            error_count++;
          end
        end
      end
    end
    // Stop a hung run; keep this check last in the block.
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_ordered_list_insert_delete_search_top failed");
      $finish;
    end
  end

  // Stimulus and run control.
  initial begin
    int send_profile [3];
    int recv_profile [3];
    int roll;
    bit growing;
    send_profile = '{25, 73, 0};
    recv_profile = '{73, 25, 0};
    growing      = 1'b0;

    // Drive every input to a known value from time zero.
    req_ch.valid   = 1'b0;
    req_ch.command = CMD_ADD;
    req_ch.value   = '0;
    rsp_ch.ready   = 1'b0;

    // Hold reset from time zero, release it on a falling edge.
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = send_profile[0];
    recv_idle_pct = recv_profile[0];

    // Every command other than add on an empty list reports empty.
    queue_cmd(CMD_DISPLAY, value_pool[0]);
    queue_cmd(CMD_DELETE,  value_pool[1]);
    queue_cmd(CMD_SEARCH,  value_pool[2]);
    // Add the extremes; the first add lands in an empty list.
    queue_cmd(CMD_ADD, value_t'(32'h8000_0000));
    queue_cmd(CMD_ADD, value_t'(32'h7fff_ffff));
    queue_cmd(CMD_ADD, value_t'(32'h0000_0000));
    queue_cmd(CMD_ADD, value_t'(32'hffff_ffff));
    // Hit and miss for search; miss for delete.
    queue_cmd(CMD_SEARCH, value_t'(32'h7fff_ffff));
    queue_cmd(CMD_SEARCH, value_t'(32'h0000_0005));
    queue_cmd(CMD_DELETE, value_t'(32'h0000_0005));
    // Duplicate: delete must drop only the copy nearest the head.
    queue_cmd(CMD_ADD,    value_t'(32'h8000_0000));
    queue_cmd(CMD_DELETE, value_t'(32'h8000_0000));
    // Fill to capacity, overflow once, then list everything.
    for (int k = 0; k < 12; k++) begin
      queue_cmd(CMD_ADD, (k % 2) ? value_t'($urandom) : value_t'(k));
    end
    queue_cmd(CMD_ADD, value_t'(32'h1234_5678));
    queue_cmd(CMD_DISPLAY, value_t'($urandom));

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_profile[p];
      recv_idle_pct = recv_profile[p];
      // Alternate bursts that grow the list toward full and shrink it
      // toward empty, so both ends are visited with random content.
      for (int n = 0; n < RANDOM_CMDS; n++) begin
        if (n % BURST_LEN == 0) begin
          growing = !growing;
        end
        roll = $urandom_range(99);
        if (growing) begin
          if (roll < 65) begin
            queue_cmd(CMD_ADD, pick_value());
          end else if (roll < 75) begin
            queue_cmd(CMD_DELETE, pick_value());
          end else if (roll < 90) begin
            queue_cmd(CMD_SEARCH, pick_value());
          end else begin
            queue_cmd(CMD_DISPLAY, value_t'($urandom));
          end
        end else begin
          if (roll < 10) begin
            queue_cmd(CMD_ADD, pick_value());
          end else if (roll < 70) begin
            queue_cmd(CMD_DELETE, pick_value());
          end else if (roll < 85) begin
            queue_cmd(CMD_SEARCH, pick_value());
          end else begin
            queue_cmd(CMD_DISPLAY, value_t'($urandom));
          end
        end
      end
      // Drain: every command sent and every owed result received.
      while (pending_cmds.size() != 0 || req_ch.valid || owed_results.size() != 0) begin
        @(posedge clk);
      end
    end

    // Let any stray response show up before the verdict.
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_ordered_list_insert_delete_search_top passed");
    end else begin
      $display("tb_ordered_list_insert_delete_search_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/olist_pkg.sv
rtl/olist_req_if.sv
rtl/olist_rsp_if.sv
rtl/olist_ram.sv
rtl/ordered_list_insert_delete_search_top.sv
bench/tb_ordered_list_insert_delete_search_top.sv
